// ----- design/gnms_pkg.sv -----
// Shared types and constants for the greedy box suppression block.
package gnms_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int IOU_LAT        = 4;
    localparam logic [15:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic        valid;
        logic        done;
        logic        supp;
        logic [15:0] x1;
        logic [15:0] y1;
        logic [15:0] x2;
        logic [15:0] y2;
        logic [15:0] score;
        logic [6:0]  cls;
    } entry_t;

endpackage

// ----- design/greedy_box_suppression.sv -----
// Top level: greedy per-class box suppression over a cell chain.
//
// Input channel (in_valid/in_stall) takes one box per transfer. Boxes are
// insert-sorted by descending score into a chain of MAX_BOXES cells in the
// cycle they are taken, so a set streams in at one box per cycle. A transfer
// with set_end closes the set; in_stall stays high until all its results are
// out of the internal pending stage.
// Suppression rotates the chain through a 4-stage overlap pipeline. Each lap
// finds at most one survivor; a set with K survivors needs K + 1 laps. An
// empty set gives one no_boxes result.
// Results leave through an output register (out_valid/out_stall); while the
// receiver stalls, the rotation holds whenever a new survivor must move out.
// Past MAX_BOXES, the lowest-scored box is dropped and every result of that
// set carries overflowed.
// Reset empties the chain, sets iou_threshold to 29491 and drops any result.
// iou_threshold is written when iou_threshold_wr_en is high; write only idle.
module greedy_box_suppression
#(
    parameter int MAX_BOXES  = gnms_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = gnms_pkg::COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               iou_threshold_wr_en,
    input  logic [15:0]        iou_threshold,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] box_x1,
    input  logic signed [15:0] box_y1,
    input  logic signed [15:0] box_x2,
    input  logic signed [15:0] box_y2,
    input  logic [15:0]        score,
    input  logic [6:0]         class_index,
    input  logic               set_end,
    input  logic               carries_nothing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] kept_x1,
    output logic signed [15:0] kept_y1,
    output logic signed [15:0] kept_x2,
    output logic signed [15:0] kept_y2,
    output logic [15:0]        kept_score,
    output logic [6:0]         kept_class,
    output logic               final_result,
    output logic               no_boxes,
    output logic               overflowed
);
    import gnms_pkg::*;

    localparam int LAP = MAX_BOXES + IOU_LAT;
    localparam int LCW = $clog2(LAP);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [LCW-1:0] lap_reg, lap_next;
    logic           ref_valid_reg, ref_valid_next;
    entry_t         ref_reg, ref_next;
    logic           pend_valid_reg, pend_valid_next;
    entry_t         pend_reg, pend_next;
    logic           ovf_reg, ovf_next;
    logic [15:0]    thr_reg;
    logic           out_valid_reg, out_valid_next;
    entry_t         out_reg, out_next;
    logic           out_final_reg, out_final_next;
    logic           out_empty_reg, out_empty_next;
    logic           out_ovf_reg, out_ovf_next;

    entry_t ent [MAX_BOXES];
    logic   cond [MAX_BOXES];
    entry_t new_e, head_e, ring_in, ring_out;
    logic   accept, ins_en, rot_en, clr_en, cand, cmp_en, out_free;
    logic signed [COORD_BITS-1:0] cx1, cy1, cx2, cy2;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign ins_en   = accept && !carries_nothing;
    assign out_free = !out_valid_reg || !out_stall;
    assign head_e   = ent[0];
    assign cand     = head_e.valid && !head_e.done && !head_e.supp && !ref_valid_reg;
    assign cmp_en   = ref_valid_reg && head_e.valid && !head_e.done && !head_e.supp
                      && (head_e.cls == ref_reg.cls);
    assign rot_en   = (state_reg == ST_RUN) && (!cand || !pend_valid_reg || out_free);
    assign clr_en   = (state_reg == ST_FLUSH) && out_free;

    always_comb
    begin
        cx1 = box_x1[COORD_BITS-1:0];
        cy1 = box_y1[COORD_BITS-1:0];
        cx2 = box_x2[COORD_BITS-1:0];
        cy2 = box_y2[COORD_BITS-1:0];
        new_e.valid = 1'b1;
        new_e.done  = 1'b0;
        new_e.supp  = 1'b0;
        new_e.x1    = 16'(cx1);
        new_e.y1    = 16'(cy1);
        new_e.x2    = 16'(cx2);
        new_e.y2    = 16'(cy2);
        new_e.score = score;
        new_e.cls   = class_index;
        ring_in      = head_e;
        ring_in.done = head_e.done | cand;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BOXES; gi++)
        begin : g_cell
            entry_t p_e;
            entry_t n_e;
            logic   p_c;
            if (gi == 0)
            begin : g_first
                assign p_e = '0;
                assign p_c = 1'b0;
            end
            else
            begin : g_mid
                assign p_e = ent[gi-1];
                assign p_c = cond[gi-1];
            end
            if (gi == MAX_BOXES - 1)
            begin : g_last
                assign n_e = ring_out;
            end
            else
            begin : g_inner
                assign n_e = ent[gi+1];
            end
            gnms_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ins_en    (ins_en),
                .rot_en    (rot_en),
                .clr_en    (clr_en),
                .new_e     (new_e),
                .prev_e    (p_e),
                .prev_cond (p_c),
                .next_e    (n_e),
                .cur_e     (ent[gi]),
                .cond      (cond[gi])
            );
        end
    endgenerate

    gnms_iou #(.COORD_BITS(COORD_BITS)) u_iou
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (rot_en),
        .in_e   (ring_in),
        .in_cmp (cmp_en),
        .ref_e  (ref_reg),
        .thr    (thr_reg),
        .out_e  (ring_out)
    );

    always_comb
    begin
        state_next      = state_reg;
        lap_next        = lap_reg;
        ref_valid_next  = ref_valid_reg;
        ref_next        = ref_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        out_final_next  = out_final_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ins_en && ent[MAX_BOXES-1].valid)
                begin
                    ovf_next = 1'b1;
                end
                if (accept && set_end)
                begin
                    lap_next        = '0;
                    ref_valid_next  = 1'b0;
                    pend_valid_next = 1'b0;
                    if (carries_nothing && !ent[0].valid)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (rot_en)
                begin
                    if (cand)
                    begin
                        ref_next        = head_e;
                        ref_valid_next  = 1'b1;
                        pend_next       = head_e;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_final_next = 1'b0;
                            out_empty_next = 1'b0;
                            out_ovf_next   = ovf_reg;
                        end
                    end
                    if (lap_reg == LCW'(LAP - 1))
                    begin
                        lap_next       = '0;
                        ref_valid_next = 1'b0;
                        if (!ref_valid_reg && !cand)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        lap_next = lap_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_final_next  = 1'b1;
                    out_empty_next  = 1'b0;
                    out_ovf_next    = ovf_reg;
                    pend_valid_next = 1'b0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_final_next = 1'b1;
                    out_empty_next = 1'b1;
                    out_ovf_next   = 1'b0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lap_reg        <= '0;
            ref_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= THR_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            lap_reg        <= lap_next;
            ref_valid_reg  <= ref_valid_next;
            pend_valid_reg <= pend_valid_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
            if (iou_threshold_wr_en)
            begin
                thr_reg <= iou_threshold;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ref_reg       <= ref_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
        out_final_reg <= out_final_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign kept_x1      = out_reg.x1;
    assign kept_y1      = out_reg.y1;
    assign kept_x2      = out_reg.x2;
    assign kept_y2      = out_reg.y2;
    assign kept_score   = out_reg.score;
    assign kept_class   = out_reg.cls;
    assign final_result = out_final_reg;
    assign no_boxes     = out_empty_reg;
    assign overflowed   = out_ovf_reg;

endmodule

// ----- design/gnms_cell.sv -----
// One slot of the sorted box chain: sorted insert, ring rotation and clear.
module gnms_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ins_en,
    input  logic            rot_en,
    input  logic            clr_en,
    input  gnms_pkg::entry_t new_e,
    input  gnms_pkg::entry_t prev_e,
    input  logic            prev_cond,
    input  gnms_pkg::entry_t next_e,
    output gnms_pkg::entry_t cur_e,
    output logic            cond
);
    import gnms_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;

    assign cond = !valid_reg || (data_reg.score < new_e.score);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (clr_en)
        begin
            valid_next = 1'b0;
        end
        else if (rot_en)
        begin
            valid_next = next_e.valid;
            data_next  = next_e;
        end
        else if (ins_en)
        begin
            if (cond && !prev_cond)
            begin
                valid_next = 1'b1;
                data_next  = new_e;
            end
            else if (prev_cond)
            begin
                valid_next = prev_e.valid;
                data_next  = prev_e;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        cur_e       = data_reg;
        cur_e.valid = valid_reg;
    end

endmodule

// ----- design/gnms_iou.sv -----
// Pipelined overlap test against the reference box, part of the ring.
module gnms_iou
#(
    parameter int COORD_BITS = gnms_pkg::COORD_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  gnms_pkg::entry_t in_e,
    input  logic             in_cmp,
    input  gnms_pkg::entry_t ref_e,
    input  logic [15:0]      thr,
    output gnms_pkg::entry_t out_e
);
    import gnms_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int UW  = PW + 2;
    localparam int SPL = UW / 2;
    localparam int HW  = UW - SPL;

    logic signed [DW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [DW-1:0] iw_raw, ih_raw, iw, ih;

    entry_t s1_e_reg, s2_e_reg, s3_e_reg, s4_e_reg;
    logic   s1_cmp_reg, s2_cmp_reg, s3_cmp_reg, s4_cmp_reg;
    logic signed [DW-1:0] iw_reg, ih_reg, aw_reg, ah_reg, bw_reg, bh_reg;
    logic signed [PW-1:0] inter_reg, area_a_reg, area_b_reg;
    logic signed [PW-1:0] inter3_reg, inter4_reg;
    logic signed [UW-1:0] uni;
    logic signed [UW-1:0] uni_reg;
    logic [16+SPL-1:0]    plo_reg;
    logic [16+HW-1:0]     phi_reg;
    logic [16+UW:0]       rhs;
    logic [16+UW:0]       lhs;
    logic                 hit;

    always_comb
    begin
        ax1 = DW'(signed'(ref_e.x1[CW-1:0]));
        ay1 = DW'(signed'(ref_e.y1[CW-1:0]));
        ax2 = DW'(signed'(ref_e.x2[CW-1:0]));
        ay2 = DW'(signed'(ref_e.y2[CW-1:0]));
        bx1 = DW'(signed'(in_e.x1[CW-1:0]));
        by1 = DW'(signed'(in_e.y1[CW-1:0]));
        bx2 = DW'(signed'(in_e.x2[CW-1:0]));
        by2 = DW'(signed'(in_e.y2[CW-1:0]));
        iw_raw = ((ax2 < bx2) ? ax2 : bx2) - ((ax1 > bx1) ? ax1 : bx1);
        ih_raw = ((ay2 < by2) ? ay2 : by2) - ((ay1 > by1) ? ay1 : by1);
        iw = (iw_raw < 0) ? '0 : iw_raw;
        ih = (ih_raw < 0) ? '0 : ih_raw;
    end

    assign uni = UW'(area_a_reg) + UW'(area_b_reg) - UW'(inter_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_e_reg   <= '0;
            s2_e_reg   <= '0;
            s3_e_reg   <= '0;
            s4_e_reg   <= '0;
            s1_cmp_reg <= 1'b0;
            s2_cmp_reg <= 1'b0;
            s3_cmp_reg <= 1'b0;
            s4_cmp_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_e_reg   <= in_e;
            s2_e_reg   <= s1_e_reg;
            s3_e_reg   <= s2_e_reg;
            s4_e_reg   <= s3_e_reg;
            s1_cmp_reg <= in_cmp;
            s2_cmp_reg <= s1_cmp_reg;
            s3_cmp_reg <= s2_cmp_reg && (uni > 0);
            s4_cmp_reg <= s3_cmp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            iw_reg     <= iw;
            ih_reg     <= ih;
            aw_reg     <= ax2 - ax1;
            ah_reg     <= ay2 - ay1;
            bw_reg     <= bx2 - bx1;
            bh_reg     <= by2 - by1;
            inter_reg  <= iw_reg * ih_reg;
            area_a_reg <= aw_reg * ah_reg;
            area_b_reg <= bw_reg * bh_reg;
            uni_reg    <= uni;
            inter3_reg <= inter_reg;
            plo_reg    <= thr * uni_reg[SPL-1:0];
            phi_reg    <= thr * uni_reg[UW-1:SPL];
            inter4_reg <= inter3_reg;
        end
    end

    always_comb
    begin
        rhs = (17+UW)'({phi_reg, {SPL{1'b0}}}) + (17+UW)'(plo_reg);
        lhs = (17+UW)'({inter4_reg, 16'h0000});
        hit = s4_cmp_reg && (lhs > rhs);
        out_e = s4_e_reg;
        out_e.supp = s4_e_reg.supp | hit;
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench for greedy_box_suppression: scoreboard class, drivers, checks.
`timescale 1ns / 1ps

class nms_scoreboard;
    typedef struct {
        logic [15:0] x1, y1, x2, y2, sc;
        logic [6:0]  cls;
        logic        fin, nob, ovf;
    } kept_t;

    logic [15:0] thr;
    logic [15:0] bx1[64], by1[64], bx2[64], by2[64], bsc[64];
    logic [6:0]  bcl[64];
    int          held;
    bit          ovf_seen;
    kept_t       pending[$];
    int          errors;

    function new();
        thr = 16'd29491;
        held = 0;
        ovf_seen = 0;
        errors = 0;
    endfunction

    function bit overlap(int i, int j);
        longint ax1, ay1, ax2, ay2, cx1, cy1, cx2, cy2, iw, ih, inter, un;
        ax1 = $signed(bx1[i]); ay1 = $signed(by1[i]);
        ax2 = $signed(bx2[i]); ay2 = $signed(by2[i]);
        cx1 = $signed(bx1[j]); cy1 = $signed(by1[j]);
        cx2 = $signed(bx2[j]); cy2 = $signed(by2[j]);
        iw = ((ax2 < cx2) ? ax2 : cx2) - ((ax1 > cx1) ? ax1 : cx1);
        ih = ((ay2 < cy2) ? ay2 : cy2) - ((ay1 > cy1) ? ay1 : cy1);
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        un = (ax2 - ax1) * (ay2 - ay1) + (cx2 - cx1) * (cy2 - cy1) - inter;
        if (un <= 0) return 0;
        return inter * 65536 > longint'(thr) * un;
    endfunction

    function void note_input(logic [15:0] x1, y1, x2, y2, sc, logic [6:0] cl,
                             bit last, bit empty);
        int    pos, k;
        bit    supp[64];
        kept_t r;
        if (!empty)
        begin
            pos = 0;
            while (pos < held && bsc[pos] >= sc) pos++;
            k = -1;
            if (held >= 64)
            begin
                ovf_seen = 1;
                if (pos < 64) k = 63;
            end
            else
            begin
                k = held;
                held++;
            end
            if (k >= 0)
            begin
                for (; k > pos; k--)
                begin
                    bx1[k] = bx1[k-1]; by1[k] = by1[k-1]; bx2[k] = bx2[k-1];
                    by2[k] = by2[k-1]; bsc[k] = bsc[k-1]; bcl[k] = bcl[k-1];
                end
                bx1[pos] = x1; by1[pos] = y1; bx2[pos] = x2; by2[pos] = y2;
                bsc[pos] = sc; bcl[pos] = cl;
            end
        end
        if (!last) return;
        if (held == 0)
        begin
            r = '{0, 0, 0, 0, 0, 0, 1, 1, 0};
            pending = {pending, r};
        end
        else
        begin
            foreach (supp[i]) supp[i] = 0;
            for (int i = 0; i < held; i++)
            begin
                if (supp[i]) continue;
                r = '{bx1[i], by1[i], bx2[i], by2[i], bsc[i], bcl[i], 0, 0, ovf_seen};
                pending = {pending, r};
                for (int j = i + 1; j < held; j++)
                    if (!supp[j] && bcl[j] == bcl[i] && overlap(i, j)) supp[j] = 1;
            end
            pending[$].fin = 1;
        end
        held = 0;
        ovf_seen = 0;
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(kept_t got);
        kept_t e;
        if (pending.size() == 0)
        begin
            report("result with nothing expected");
            return;
        end
        e = pending.pop_front();
        if (got.x1 !== e.x1) report($sformatf("kept_x1 %h exp %h", got.x1, e.x1));
        if (got.y1 !== e.y1) report($sformatf("kept_y1 %h exp %h", got.y1, e.y1));
        if (got.x2 !== e.x2) report($sformatf("kept_x2 %h exp %h", got.x2, e.x2));
        if (got.y2 !== e.y2) report($sformatf("kept_y2 %h exp %h", got.y2, e.y2));
        if (got.sc !== e.sc) report($sformatf("kept_score %h exp %h", got.sc, e.sc));
        if (got.cls !== e.cls) report($sformatf("kept_class %h exp %h", got.cls, e.cls));
        if (got.fin !== e.fin) report($sformatf("final_result %b exp %b", got.fin, e.fin));
        if (got.nob !== e.nob) report($sformatf("no_boxes %b exp %b", got.nob, e.nob));
        if (got.ovf !== e.ovf) report($sformatf("overflowed %b exp %b", got.ovf, e.ovf));
    endtask
endclass

module tb_top;
    import gnms_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               thr_wr_en = 0;
    logic [15:0]        thr_data = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [15:0] box_x1 = 0, box_y1 = 0, box_x2 = 0, box_y2 = 0;
    logic [15:0]        score = 0;
    logic [6:0]         class_index = 0;
    logic               set_end = 0, carries_nothing = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [15:0] kept_x1, kept_y1, kept_x2, kept_y2;
    logic [15:0]        kept_score;
    logic [6:0]         kept_class;
    logic               final_result, no_boxes, overflowed;

    nms_scoreboard sb = new();
    bit            sink_calm = 0;
    bit            src_calm = 0;
    int            idle_cycles = 0;
    localparam int WATCHDOG = 200000;

    greedy_box_suppression dut (
        .clk(clk), .rst_n(rst_n),
        .iou_threshold_wr_en(thr_wr_en), .iou_threshold(thr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .box_x1(box_x1), .box_y1(box_y1), .box_x2(box_x2), .box_y2(box_y2),
        .score(score), .class_index(class_index),
        .set_end(set_end), .carries_nothing(carries_nothing),
        .out_valid(out_valid), .out_stall(out_stall),
        .kept_x1(kept_x1), .kept_y1(kept_y1), .kept_x2(kept_x2), .kept_y2(kept_y2),
        .kept_score(kept_score), .kept_class(kept_class),
        .final_result(final_result), .no_boxes(no_boxes), .overflowed(overflowed)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{kept_x1, kept_y1, kept_x2, kept_y2, kept_score,
                              kept_class, final_result, no_boxes, overflowed});
    end

    // receiver stall bursts
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!sink_calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 13);
                out_stall <= 1;
                repeat (n) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("greedy_box_suppression regression: fail");
            $finish;
        end
    end

    task send_box(logic [15:0] x1, y1, x2, y2, sc, logic [6:0] cl, bit last, bit empty);
        if (!src_calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1;
        box_x1 <= x1; box_y1 <= y1; box_x2 <= x2; box_y2 <= y2;
        score <= sc; class_index <= cl; set_end <= last; carries_nothing <= empty;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(x1, y1, x2, y2, sc, cl, last, empty);
    endtask

    task drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2 * (MAX_BOXES_DEF + IOU_LAT) + 20) @(posedge clk);
    endtask

    task write_thr(logic [15:0] v);
        drain();
        thr_wr_en <= 1;
        thr_data <= v;
        @(posedge clk);
        thr_wr_en <= 0;
        sb.thr = v;
    endtask

    task random_set(int n, int ncls, bit close_empty);
        logic [15:0] x, y, sc;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                x = 16'($urandom); y = 16'($urandom);
                send_box(x, y, 16'($urandom), 16'($urandom), 16'($urandom),
                         7'($urandom), 0, $urandom_range(0, 5) == 0);
            end
            else
            begin
                x = 16'($urandom_range(0, 200)); y = 16'($urandom_range(0, 200));
                sc = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3)) * 16'h4000
                                               : 16'($urandom);
                send_box(x, y, x + 16'($urandom_range(0, 60)),
                         y + 16'($urandom_range(0, 60)),
                         sc, 7'($urandom_range(0, ncls - 1)), 0, 0);
            end
        end
        if (close_empty)
            send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 7'($urandom), 1, 1);
        else
        begin
            x = 16'($urandom_range(0, 200)); y = 16'($urandom_range(0, 200));
            send_box(x, y, x + 16'd30, y + 16'd30, 16'($urandom),
                     7'($urandom_range(0, ncls - 1)), 1, 0);
        end
    endtask

    initial
    begin
        int items;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: empty set, extremes, overlap, degenerate, tie
        send_box(0, 0, 0, 0, 0, 0, 1, 1);
        send_box(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 7'h7f, 0, 0);
        send_box(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 7'h7f, 0, 0);
        send_box(0, 0, 100, 100, 16'h8000, 7'h7f, 0, 0);
        send_box(5, 5, 105, 105, 16'h8000, 7'h7f, 0, 0);
        send_box(5, 5, 105, 105, 16'h8000, 7'h00, 0, 0);
        send_box(10, 10, 5, 5, 16'h9000, 7'h7f, 0, 0);
        send_box(16'hffff, 16'h1234, 16'h5555, 16'haaaa, 16'h5555, 7'h2a, 1, 0);
        send_box(50, 50, 60, 60, 16'h1000, 3, 0, 0);
        send_box(50, 50, 60, 60, 16'h1000, 3, 1, 0);
        write_thr(16'h0000);
        send_box(0, 0, 10, 10, 16'h2000, 1, 0, 0);
        send_box(9, 9, 20, 20, 16'h1000, 1, 1, 0);
        write_thr(16'hffff);
        send_box(0, 0, 10, 10, 16'h2000, 1, 0, 0);
        send_box(0, 0, 10, 10, 16'h1000, 1, 1, 0);
        // overflow: 70 boxes
        write_thr(16'd29491);
        random_set(69, 4, 0);
        random_set(75, 2, 1);
        drain();
        items = 170;
        while (items < 400)
        begin
            if ($urandom_range(0, 5) == 0)
                write_thr($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1) * 16'hffff)
                                                    : 16'($urandom));
            if ($urandom_range(0, 6) == 0)
                drain();
            if (items > 340)
            begin
                src_calm = 1;
                sink_calm = 1;
            end
            begin
                int n;
                n = $urandom_range(0, 12);
                random_set(n, $urandom_range(1, 4), $urandom_range(0, 3) == 0);
                items += n + 1;
            end
        end
        drain();
        if (sb.pending.size() == 0 && sb.errors == 0)
            $display("greedy_box_suppression regression: pass");
        else
            $display("greedy_box_suppression regression: fail");
        $finish;
    end
endmodule
